// ===== hw/rtl/crw_pkg.sv =====
// ----------------------------------------------------------------------------
// crw_pkg
// Shared types and constants of the controller reply watcher.
// ----------------------------------------------------------------------------
package crw_pkg;

  localparam int MAX_LINE_DEF  = 255;
  localparam int HEAD_LEN      = 6;
  localparam int HEAD_IW       = $clog2(HEAD_LEN);

  localparam logic [7:0] SILENCE_RESET = 8'd10;

  // Input beat kinds.
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_CMD  = 2'd2;

  // Result event codes.
  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_PROBE   = 4'd1;
  localparam logic [3:0] EV_OK      = 4'd2;
  localparam logic [3:0] EV_ERROR   = 4'd3;
  localparam logic [3:0] EV_ALARM   = 4'd4;
  localparam logic [3:0] EV_STATUS  = 4'd5;
  localparam logic [3:0] EV_PAUSED  = 4'd6;
  localparam logic [3:0] EV_TIMEOUT = 4'd7;
  localparam logic [3:0] EV_PAYLOAD = 4'd8;

  // Characters the parser cares about.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef logic [7:0] head_t [HEAD_LEN];

  // Outcome of classifying one finished line.
  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] code;
    logic       clr_quiet;
    logic       end_await;
    logic       set_pause;
  } line_res_t;

  // One result beat.
  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] code;
    logic [7:0] len;
  } result_t;

endpackage

// ===== hw/rtl/cnc_reply_watcher.sv =====
// ----------------------------------------------------------------------------
// cnc_reply_watcher
// Host-side watcher of the reply stream of a motion controller.
// ----------------------------------------------------------------------------
// Every input beat (a reply byte, a one-second silence tick or a command
// start) yields exactly one result beat, in the cycle after it is taken. The
// line state is updated in the same cycle that the beat is taken, and the
// result sits in a single output register, so the block takes one beat per
// clock for as long as that register is empty or being read; it stalls only
// while a result is waiting and the sink is not ready. silence_limit is
// written through cfg_we/cfg_wdata and resets to 10.
module cnc_reply_watcher #(
  parameter int MAX_LINE = crw_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] reply_code, [15:8] line_length
  output logic [3:0]  m_axis_tuser    // [3:0] event_res
);
  import crw_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);

  logic [7:0]       silence_limit;
  head_t            head;
  logic [CNT_W-1:0] char_count, char_count_next;
  logic             byte_seen, byte_seen_next;
  logic             colon_seen, colon_seen_next;
  logic             digits_done, digits_done_next;
  logic [7:0]       code_acc, code_acc_next;
  logic [7:0]       quiet_secs, quiet_secs_next;
  logic             awaiting, awaiting_next;
  logic             pause_noted, pause_noted_next;

  logic             accept;
  logic [7:0]       c;
  logic             is_data;
  logic [CNT_W-1:0] cnt_inc;
  logic             colon_upd, digits_upd;
  logic [7:0]       code_upd;
  logic [3:0]       digit;
  logic [11:0]      code_mul;
  logic             head_we;
  logic             do_fin;
  logic [CNT_W-1:0] fin_n;
  logic [7:0]       fin_code;
  logic [7:0]       fin_len;
  logic [7:0]       quiet_inc;
  line_res_t        cls;
  result_t          res;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign c       = s_axis_tdata;
  assign is_data = (s_axis_tuser == MODE_BYTE) && c != CH_CR && c != CH_LF;
  assign cnt_inc = char_count + CNT_W'(1);
  assign head_we = accept && is_data && 32'(char_count) < HEAD_LEN;

  // Decimal code after the first colon, saturating at 255.
  assign digit    = 4'(c - CH_ZERO);
  assign code_mul = {1'b0, code_acc, 3'b000} + {3'b000, code_acc, 1'b0} + 12'(digit);

  always_comb begin
    colon_upd  = colon_seen;
    digits_upd = digits_done;
    code_upd   = code_acc;
    if (!colon_seen) begin
      colon_upd = (c == CH_COLON);
    end else if (!digits_done) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        code_upd = (code_mul > 12'd255) ? 8'hFF : code_mul[7:0];
      end else begin
        digits_upd = 1'b1;
      end
    end
  end

  // Where a line ends, and with which length and code.
  always_comb begin
    do_fin   = 1'b0;
    fin_n    = char_count;
    fin_code = code_acc;
    case (s_axis_tuser)
      MODE_BYTE: begin
        if (c == CH_LF) begin
          do_fin = 1'b1;
        end else if (is_data && 32'(cnt_inc) >= MAX_LINE) begin
          do_fin   = 1'b1;
          fin_n    = cnt_inc;
          fin_code = code_upd;
        end
      end
      MODE_TICK: begin
        do_fin = byte_seen;
      end
      default: begin
      end
    endcase
  end

  crw_line_class #(
    .CNT_W (CNT_W)
  ) u_class (
    .head        (head),
    .n           (fin_n),
    .code        (fin_code),
    .awaiting    (awaiting),
    .pause_noted (pause_noted),
    .res         (cls)
  );

  assign fin_len   = (32'(fin_n) > 255) ? 8'hFF : 8'(fin_n);
  assign quiet_inc = (quiet_secs == 8'hFF) ? quiet_secs : quiet_secs + 8'd1;

  always_comb begin
    char_count_next  = char_count;
    byte_seen_next   = byte_seen;
    colon_seen_next  = colon_seen;
    digits_done_next = digits_done;
    code_acc_next    = code_acc;
    quiet_secs_next  = quiet_secs;
    awaiting_next    = awaiting;
    pause_noted_next = pause_noted;
    res              = '0;
    if (do_fin) begin
      char_count_next  = '0;
      byte_seen_next   = 1'b0;
      colon_seen_next  = 1'b0;
      digits_done_next = 1'b0;
      code_acc_next    = '0;
      if (cls.clr_quiet) begin
        quiet_secs_next = '0;
      end
      if (cls.end_await) begin
        awaiting_next = 1'b0;
      end
      if (cls.set_pause) begin
        pause_noted_next = 1'b1;
      end
      res.ev   = cls.ev;
      res.code = cls.code;
      res.len  = (cls.ev != EV_NONE) ? fin_len : 8'd0;
    end else begin
      case (s_axis_tuser)
        MODE_BYTE: begin
          // A CR only marks the line as started.
          byte_seen_next = 1'b1;
          if (is_data) begin
            char_count_next  = cnt_inc;
            colon_seen_next  = colon_upd;
            digits_done_next = digits_upd;
            code_acc_next    = code_upd;
          end
        end
        MODE_TICK: begin
          if (awaiting) begin
            quiet_secs_next = quiet_inc;
            if (quiet_inc >= silence_limit) begin
              awaiting_next = 1'b0;
              res.ev        = EV_TIMEOUT;
            end else begin
              res.ev = EV_PROBE;
            end
          end
        end
        MODE_CMD: begin
          awaiting_next    = 1'b1;
          quiet_secs_next  = '0;
          pause_noted_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit <= SILENCE_RESET;
      char_count    <= '0;
      byte_seen     <= 1'b0;
      colon_seen    <= 1'b0;
      digits_done   <= 1'b0;
      code_acc      <= '0;
      quiet_secs    <= '0;
      awaiting      <= 1'b0;
      pause_noted   <= 1'b0;
    end else begin
      if (cfg_we) begin
        silence_limit <= cfg_wdata;
      end
      if (accept) begin
        char_count  <= char_count_next;
        byte_seen   <= byte_seen_next;
        colon_seen  <= colon_seen_next;
        digits_done <= digits_done_next;
        code_acc    <= code_acc_next;
        quiet_secs  <= quiet_secs_next;
        awaiting    <= awaiting_next;
        pause_noted <= pause_noted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head[char_count[HEAD_IW-1:0]] <= c;
    end
  end

  crw_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .load_data     (res),
    .can_load      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_code_only_with_reply: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[7:0] != 8'd0) |->
      (m_axis_tuser == EV_ERROR || m_axis_tuser == EV_ALARM))
    else $error("reply code on an event that carries none");

  a_no_length_on_silence: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_NONE || m_axis_tuser == EV_PROBE ||
                       m_axis_tuser == EV_TIMEOUT)) |-> m_axis_tdata[15:8] == 8'd0)
    else $error("line length on an event without a line");

  a_timeout_ends_wait: assert property (@(posedge clk) disable iff (rst)
    (accept && res.ev == EV_TIMEOUT) |=> !awaiting)
    else $error("still awaiting a reply after a timeout");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(char_count) < MAX_LINE)
    else $error("line count reached the buffer size");

endmodule

// ===== hw/rtl/crw_line_class.sv =====
// ----------------------------------------------------------------------------
// crw_line_class
// Classifies a finished line by its first characters and reports the event
// together with the state changes that it causes.
// ----------------------------------------------------------------------------
module crw_line_class #(
  parameter int CNT_W = 8
) (
  input  crw_pkg::head_t      head,
  input  logic [CNT_W-1:0]    n,
  input  logic [7:0]          code,
  input  logic                awaiting,
  input  logic                pause_noted,
  output crw_pkg::line_res_t  res
);
  import crw_pkg::*;

  logic [31:0] n32;
  logic        is_status;
  logic        m_alarm_st;
  logic        m_hold;
  logic        m_door;
  logic        m_ok;
  logic        m_error;
  logic        m_alarm;

  assign n32 = 32'(n);
  assign is_status = (head[0] == CH_LT);

  // A prefix only counts when the line is long enough to hold it.
  assign m_alarm_st = (n32 >= 32'd6) && head[1] == "A" && head[2] == "l" &&
                      head[3] == "a" && head[4] == "r" && head[5] == "m";
  assign m_hold     = (n32 >= 32'd5) && head[1] == "H" && head[2] == "o" &&
                      head[3] == "l" && head[4] == "d";
  assign m_door     = (n32 >= 32'd5) && head[1] == "D" && head[2] == "o" &&
                      head[3] == "o" && head[4] == "r";
  assign m_ok       = (n32 >= 32'd2) && head[0] == "o" && head[1] == "k";
  assign m_error    = (n32 >= 32'd5) && head[0] == "e" && head[1] == "r" &&
                      head[2] == "r" && head[3] == "o" && head[4] == "r";
  assign m_alarm    = (n32 >= 32'd5) && head[0] == "A" && head[1] == "L" &&
                      head[2] == "A" && head[3] == "R" && head[4] == "M";

  always_comb begin
    res = '0;
    if (awaiting && n32 != 32'd0) begin
      res.clr_quiet = 1'b1;
      if (is_status) begin
        if (m_alarm_st) begin
          res.ev        = EV_STATUS;
          res.end_await = 1'b1;
        end else if (!pause_noted && (m_hold || m_door)) begin
          res.ev        = EV_PAUSED;
          res.set_pause = 1'b1;
        end
      end else if (m_ok) begin
        res.ev        = EV_OK;
        res.end_await = 1'b1;
      end else if (m_error) begin
        res.ev        = EV_ERROR;
        res.code      = code;
        res.end_await = 1'b1;
      end else if (m_alarm) begin
        res.ev        = EV_ALARM;
        res.code      = code;
        res.end_await = 1'b1;
      end else begin
        res.ev = EV_PAYLOAD;
      end
    end
  end

endmodule

// ===== hw/rtl/crw_out_reg.sv =====
// ----------------------------------------------------------------------------
// crw_out_reg
// Result register between the watcher logic and the output stream.
// ----------------------------------------------------------------------------
module crw_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  crw_pkg::result_t  load_data,
  output logic              can_load,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic [3:0]        m_axis_tuser
);
  import crw_pkg::*;

  result_t held;

  // A new beat may enter when the register is empty or drains this cycle.
  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= load_data;
    end
  end

  assign m_axis_tdata = {held.len, held.code};
  assign m_axis_tuser = held.ev;

endmodule
